/* sv/m2x2_pkg.sv */
// Shared command codes and register constants for the 2x2 matrix unit.
package m2x2_pkg;

    localparam int CMD_WIDTH = 4;
    localparam int EPS_WIDTH = 31;

    typedef enum logic [CMD_WIDTH-1:0] {
        CMD_ADD       = 4'd0,
        CMD_SUB       = 4'd1,
        CMD_SCALE     = 4'd2,
        CMD_ADDSCALED = 4'd3,
        CMD_MUL       = 4'd4,
        CMD_VECMAT    = 4'd5,
        CMD_MATVEC    = 4'd6,
        CMD_DET       = 4'd7,
        CMD_NORM      = 4'd8,
        CMD_TRANSPOSE = 4'd9,
        CMD_ADJOINT   = 4'd10,
        CMD_INVERSE   = 4'd11
    } cmd_t;

    localparam logic [EPS_WIDTH-1:0] EPS_RESET = 31'd66;

endpackage

/* sv/m2x2_div.sv */
// Pipelined restoring divider that forms one rounded, saturated inverse entry.
module m2x2_div #(
    parameter int DW = 32,
    parameter int F  = 16
) (
    input  logic                 aclk,
    input  logic                 en,
    input  logic signed [DW:0]   numer,
    input  logic signed [2*DW:0] det,
    output logic [DW-1:0]        quot,
    output logic                 quot_sat
);

    localparam int OPW = DW + 1;
    localparam int DMW = 2 * DW;
    localparam int NW  = DW + 2 * F;

    logic [OPW-1:0] nabs;
    logic [DMW:0]   dabs;
    logic [DW-1:0]  nmag;
    logic [DMW-1:0] dmag;
    logic [NW-1:0]  nfull;
    logic           ovf_next;

    logic [DMW-1:0] rem_reg [0:DW];
    logic [DMW-1:0] dv_reg  [0:DW];
    logic [DW-1:0]  nb_reg  [0:DW];
    logic [DW-1:0]  q_reg   [0:DW];
    logic           neg_reg [0:DW];
    logic           ovf_reg [0:DW];

    logic           rnd_up;
    logic [DW:0]    qinc;
    logic [DW:0]    lim;
    logic [DW:0]    mag;
    logic [DW:0]    val;
    logic           sat_next;
    logic [DW-1:0]  quot_reg;
    logic           quot_sat_reg;

    always_comb begin
        nabs  = numer[OPW-1] ? -numer : numer;
        dabs  = det[DMW] ? -det : det;
        nmag  = nabs[DW-1:0];
        dmag  = dabs[DMW-1:0];
        nfull = {nmag, {(2*F){1'b0}}};
        // A quotient of 2^DW or more can only saturate.
        ovf_next = {{(3*DW-NW){1'b0}}, nfull} >= {dmag, {DW{1'b0}}};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= {{(DMW-2*F){1'b0}}, nfull[NW-1:DW]};
            dv_reg[0]  <= dmag;
            nb_reg[0]  <= nfull[DW-1:0];
            q_reg[0]   <= '0;
            neg_reg[0] <= numer[OPW-1] ^ det[DMW];
            ovf_reg[0] <= ovf_next;
        end
    end

    for (genvar k = 1; k <= DW; k++) begin : g_iter
        logic [DMW:0] trial;
        logic         ge;
        assign trial = {rem_reg[k-1], nb_reg[k-1][DW-1]};
        assign ge    = trial >= {1'b0, dv_reg[k-1]};
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= ge ? DMW'(trial - {1'b0, dv_reg[k-1]}) : trial[DMW-1:0];
                dv_reg[k]  <= dv_reg[k-1];
                nb_reg[k]  <= nb_reg[k-1] << 1;
                q_reg[k]   <= {q_reg[k-1][DW-2:0], ge};
                neg_reg[k] <= neg_reg[k-1];
                ovf_reg[k] <= ovf_reg[k-1];
            end
        end
    end

    always_comb begin
        // Round half away from zero: bump when twice the remainder reaches the divisor.
        rnd_up   = {rem_reg[DW], 1'b0} >= {1'b0, dv_reg[DW]};
        qinc     = {1'b0, q_reg[DW]} + (DW+1)'(rnd_up);
        lim      = neg_reg[DW] ? {2'b01, {(DW-1){1'b0}}} : {2'b00, {(DW-1){1'b1}}};
        sat_next = ovf_reg[DW] || (qinc > lim);
        mag      = sat_next ? lim : qinc;
        val      = neg_reg[DW] ? -mag : mag;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            quot_reg     <= val[DW-1:0];
            quot_sat_reg <= sat_next;
        end
    end

    assign quot     = quot_reg;
    assign quot_sat = quot_sat_reg;

endmodule

/* sv/m2x2_sqrt.sv */
// Pipelined integer square root of the sum of two addends, one root bit per stage.
module m2x2_sqrt #(
    parameter int DW = 32
) (
    input  logic              aclk,
    input  logic              en,
    input  logic [2*DW-1:0]   addend_a,
    input  logic [2*DW-1:0]   addend_b,
    output logic [DW:0]       root
);

    localparam int RADW = 2 * (DW + 1);
    localparam int RMW  = DW + 3;

    logic [RADW-1:0] rad_reg  [0:DW+1];
    logic [RMW-1:0]  rem_reg  [0:DW+1];
    logic [DW:0]     root_reg [0:DW+1];

    always_ff @(posedge aclk) begin
        if (en) begin
            rad_reg[0]  <= RADW'(addend_a) + RADW'(addend_b);
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
        end
    end

    for (genvar j = 1; j <= DW + 1; j++) begin : g_iter
        logic [RMW+1:0] trem;
        logic [RMW+1:0] tsub;
        logic           ge;
        assign trem = {rem_reg[j-1], rad_reg[j-1][RADW-1 -: 2]};
        assign tsub = (RMW+2)'({root_reg[j-1], 2'b01});
        assign ge   = trem >= tsub;
        always_ff @(posedge aclk) begin
            if (en) begin
                rad_reg[j]  <= rad_reg[j-1] << 2;
                rem_reg[j]  <= ge ? RMW'(trem - tsub) : trem[RMW-1:0];
                root_reg[j] <= {root_reg[j-1][DW-1:0], ge};
            end
        end
    end

    assign root = root_reg[DW+1];

endmodule

/* sv/m2x2_lane.sv */
// One result lane: two products, their sum, rounding, and a divider for the inverse.
module m2x2_lane #(
    parameter int DW = 32,
    parameter int F  = 16
) (
    input  logic                         aclk,
    input  logic                         en,
    input  logic signed [DW:0]           x1,
    input  logic signed [DW:0]           y1,
    input  logic signed [DW:0]           x2,
    input  logic signed [DW:0]           y2,
    input  logic signed [DW:0]           numer,
    input  logic signed [2*DW:0]         det,
    output logic signed [2*(DW+1):0]     sum,
    output logic [DW-1:0]                res,
    output logic                         res_sat,
    output logic [DW-1:0]                quot,
    output logic                         quot_sat
);

    localparam int OPW = DW + 1;
    localparam int SW  = 2 * OPW + 1;
    localparam int DLY = DW + 2;

    localparam logic signed [SW-1:0] HALF = {{(SW-F){1'b0}}, 1'b1, {(F-1){1'b0}}};
    localparam logic signed [SW-1:0] MAXV = {{(SW-DW+1){1'b0}}, {(DW-1){1'b1}}};
    localparam logic signed [SW-1:0] MINV = {{(SW-DW+1){1'b1}}, {(DW-1){1'b0}}};

    logic signed [2*OPW-1:0] p1_reg;
    logic signed [2*OPW-1:0] p2_reg;
    logic signed [OPW-1:0]   numer1_reg;
    logic signed [OPW-1:0]   numer2_reg;
    logic signed [SW-1:0]    sum_reg;

    logic signed [SW-1:0]    adj;
    logic signed [SW-1:0]    shr;
    logic [DW-1:0]           rnd_next;
    logic                    sat_next;

    logic [DW-1:0]           rnd_reg [0:DLY-1];
    logic                    sat_reg [0:DLY-1];

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_reg     <= x1 * y1;
            p2_reg     <= x2 * y2;
            numer1_reg <= numer;
            sum_reg    <= SW'(p1_reg) + SW'(p2_reg);
            numer2_reg <= numer1_reg;
        end
    end

    // Rounding to nearest with ties away from zero, then clipping to the data range.
    always_comb begin
        adj      = sum_reg + HALF - {{(SW-1){1'b0}}, sum_reg[SW-1]};
        shr      = adj >>> F;
        sat_next = (shr > MAXV) || (shr < MINV);
        if (shr > MAXV) begin
            rnd_next = {1'b0, {(DW-1){1'b1}}};
        end else if (shr < MINV) begin
            rnd_next = {1'b1, {(DW-1){1'b0}}};
        end else begin
            rnd_next = shr[DW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rnd_reg[0] <= rnd_next;
            sat_reg[0] <= sat_next;
            for (int i = 1; i < DLY; i++) begin
                rnd_reg[i] <= rnd_reg[i-1];
                sat_reg[i] <= sat_reg[i-1];
            end
        end
    end

    m2x2_div #(
        .DW (DW),
        .F  (F)
    ) u_div (
        .aclk     (aclk),
        .en       (en),
        .numer    (numer2_reg),
        .det      (det),
        .quot     (quot),
        .quot_sat (quot_sat)
    );

    assign sum     = sum_reg;
    assign res     = rnd_reg[DLY-1];
    assign res_sat = sat_reg[DLY-1];

endmodule

/* sv/matrix2x2_arithmetic_unit.sv */
// Top level of the 2x2 fixed-point matrix unit: operand routing, lanes, merge and output.
//
// Fully pipelined 2x2 matrix unit on signed fixed-point entries (DATA_WIDTH bits,
// FRAC_BITS of fraction, column-major). It takes one item per clock; the whole
// pipeline advances together and holds while a finished result waits on m_ready,
// so throughput is one item per cycle whenever the output side keeps up. The
// pipeline length is set by the inverse divider and the norm square root, which
// retire one quotient or root bit per stage. Four lanes each build one result
// entry from two products; the determinant used by the inverse has its own
// multiplier pair. The singular threshold register is written through the cfg
// channel; the user must write it only while the unit is idle, which the block
// itself does not enforce. It resets to 66 (Q16.16 determinant units).
module matrix2x2_arithmetic_unit
    import m2x2_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,

    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [EPS_WIDTH-1:0]         cfg_wdata,

    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [CMD_WIDTH-1:0]         s_command,
    input  logic signed [DATA_WIDTH-1:0] s_mat_a_00,
    input  logic signed [DATA_WIDTH-1:0] s_mat_a_01,
    input  logic signed [DATA_WIDTH-1:0] s_mat_a_10,
    input  logic signed [DATA_WIDTH-1:0] s_mat_a_11,
    input  logic signed [DATA_WIDTH-1:0] s_mat_b_00,
    input  logic signed [DATA_WIDTH-1:0] s_mat_b_01,
    input  logic signed [DATA_WIDTH-1:0] s_mat_b_10,
    input  logic signed [DATA_WIDTH-1:0] s_mat_b_11,
    input  logic signed [DATA_WIDTH-1:0] s_scale_factor,
    input  logic signed [DATA_WIDTH-1:0] s_vec_x,
    input  logic signed [DATA_WIDTH-1:0] s_vec_y,

    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [DATA_WIDTH-1:0] m_res_00,
    output logic signed [DATA_WIDTH-1:0] m_res_01,
    output logic signed [DATA_WIDTH-1:0] m_res_10,
    output logic signed [DATA_WIDTH-1:0] m_res_11,
    output logic                         m_singular,
    output logic                         m_saturated
);

    localparam int DW   = DATA_WIDTH;
    localparam int F    = FRAC_BITS;
    localparam int OPW  = DW + 1;
    localparam int SW   = 2 * OPW + 1;
    localparam int DETW = 2 * DW + 1;
    localparam int LAT  = DW + 4;
    localparam int CMPW = (2 * DW > EPS_WIDTH + F) ? 2 * DW : EPS_WIDTH + F;

    localparam logic signed [OPW-1:0] ONE = {{(OPW-F-1){1'b0}}, 1'b1, {F{1'b0}}};

    // The pipeline moves as one; it only waits while the output register is full
    // and not being taken.
    logic adv;
    logic accept;

    logic [EPS_WIDTH-1:0] eps_reg;

    logic valid_reg [0:LAT-1];
    cmd_t cmd_reg   [0:LAT-1];

    // Operand routing into the lanes.
    logic signed [OPW-1:0] ea [0:3];
    logic signed [OPW-1:0] eb [0:3];
    logic signed [OPW-1:0] es;
    logic signed [OPW-1:0] ex;
    logic signed [OPW-1:0] ey;
    logic signed [OPW-1:0] op_x1 [0:3];
    logic signed [OPW-1:0] op_y1 [0:3];
    logic signed [OPW-1:0] op_x2 [0:3];
    logic signed [OPW-1:0] op_y2 [0:3];
    logic signed [OPW-1:0] op_nm [0:3];

    // Determinant path for the inverse.
    logic signed [2*DW-1:0] dp1_reg;
    logic signed [2*DW-1:0] dp2_reg;
    logic signed [DETW-1:0] det_reg;
    logic [DETW-1:0]        det_abs;
    logic                   sing_next;
    logic                   sing_reg [0:DW+1];

    logic signed [SW-1:0] lane_sum  [0:3];
    logic [DW-1:0]        lane_res  [0:3];
    logic                 lane_rsat [0:3];
    logic [DW-1:0]        lane_quot [0:3];
    logic                 lane_qsat [0:3];

    logic [DW:0]   root;
    logic          root_sat;

    logic [DW-1:0] res_next [0:3];
    logic          sing_out_next;
    logic          sat_out_next;

    logic                 m_valid_reg;
    logic [DW-1:0]        res_reg [0:3];
    logic                 m_singular_reg;
    logic                 m_saturated_reg;

    assign adv       = !m_valid_reg || m_ready;
    assign s_ready   = adv;
    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eps_reg <= EPS_RESET;
        end else if (cfg_valid) begin
            eps_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LAT; i++) begin
                valid_reg[i] <= 1'b0;
            end
        end else if (adv) begin
            valid_reg[0] <= accept;
            for (int i = 1; i < LAT; i++) begin
                valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            cmd_reg[0] <= cmd_t'(s_command);
            for (int i = 1; i < LAT; i++) begin
                cmd_reg[i] <= cmd_reg[i-1];
            end
        end
    end

    always_comb begin
        ea[0] = OPW'(s_mat_a_00);
        ea[1] = OPW'(s_mat_a_01);
        ea[2] = OPW'(s_mat_a_10);
        ea[3] = OPW'(s_mat_a_11);
        eb[0] = OPW'(s_mat_b_00);
        eb[1] = OPW'(s_mat_b_01);
        eb[2] = OPW'(s_mat_b_10);
        eb[3] = OPW'(s_mat_b_11);
        es    = OPW'(s_scale_factor);
        ex    = OPW'(s_vec_x);
        ey    = OPW'(s_vec_y);

        for (int i = 0; i < 4; i++) begin
            op_x1[i] = '0;
            op_y1[i] = '0;
            op_x2[i] = '0;
            op_y2[i] = '0;
            op_nm[i] = '0;
        end

        // Each lane computes x1*y1 + x2*y2. Plain values ride through as
        // value*1.0 so that they share the rounding and clipping of products.
        case (s_command)
            CMD_ADD: begin
                for (int i = 0; i < 4; i++) begin
                    op_x1[i] = ea[i];
                    op_y1[i] = ONE;
                    op_x2[i] = eb[i];
                    op_y2[i] = ONE;
                end
            end
            CMD_SUB: begin
                for (int i = 0; i < 4; i++) begin
                    op_x1[i] = ea[i];
                    op_y1[i] = ONE;
                    op_x2[i] = -eb[i];
                    op_y2[i] = ONE;
                end
            end
            CMD_SCALE: begin
                for (int i = 0; i < 4; i++) begin
                    op_x1[i] = ea[i];
                    op_y1[i] = es;
                end
            end
            CMD_ADDSCALED: begin
                for (int i = 0; i < 4; i++) begin
                    op_x1[i] = ea[i];
                    op_y1[i] = ONE;
                    op_x2[i] = eb[i];
                    op_y2[i] = es;
                end
            end
            CMD_MUL: begin
                op_x1[0] = ea[0]; op_y1[0] = eb[0]; op_x2[0] = ea[2]; op_y2[0] = eb[1];
                op_x1[1] = ea[1]; op_y1[1] = eb[0]; op_x2[1] = ea[3]; op_y2[1] = eb[1];
                op_x1[2] = ea[0]; op_y1[2] = eb[2]; op_x2[2] = ea[2]; op_y2[2] = eb[3];
                op_x1[3] = ea[1]; op_y1[3] = eb[2]; op_x2[3] = ea[3]; op_y2[3] = eb[3];
            end
            CMD_VECMAT: begin
                op_x1[0] = ex; op_y1[0] = ea[0]; op_x2[0] = ey; op_y2[0] = ea[1];
                op_x1[1] = ex; op_y1[1] = ea[2]; op_x2[1] = ey; op_y2[1] = ea[3];
            end
            CMD_MATVEC: begin
                op_x1[0] = ex; op_y1[0] = ea[0]; op_x2[0] = ey; op_y2[0] = ea[2];
                op_x1[1] = ex; op_y1[1] = ea[1]; op_x2[1] = ey; op_y2[1] = ea[3];
            end
            CMD_DET: begin
                op_x1[0] = ea[0]; op_y1[0] = ea[3]; op_x2[0] = -ea[2]; op_y2[0] = ea[1];
            end
            CMD_NORM: begin
                // Lanes 0 and 1 each give two of the four squares summed for the root.
                op_x1[0] = ea[0]; op_y1[0] = ea[0]; op_x2[0] = ea[1]; op_y2[0] = ea[1];
                op_x1[1] = ea[2]; op_y1[1] = ea[2]; op_x2[1] = ea[3]; op_y2[1] = ea[3];
            end
            CMD_TRANSPOSE: begin
                op_x1[0] = ea[0];
                op_x1[1] = ea[2];
                op_x1[2] = ea[1];
                op_x1[3] = ea[3];
                for (int i = 0; i < 4; i++) begin
                    op_y1[i] = ONE;
                end
            end
            CMD_ADJOINT: begin
                op_x1[0] = ea[3];
                op_x1[1] = -ea[1];
                op_x1[2] = -ea[2];
                op_x1[3] = ea[0];
                for (int i = 0; i < 4; i++) begin
                    op_y1[i] = ONE;
                end
            end
            CMD_INVERSE: begin
                // The rounded path carries A itself for the singular case; the
                // adjoint entries go to the dividers as numerators.
                for (int i = 0; i < 4; i++) begin
                    op_x1[i] = ea[i];
                    op_y1[i] = ONE;
                end
                op_nm[0] = ea[3];
                op_nm[1] = -ea[1];
                op_nm[2] = -ea[2];
                op_nm[3] = ea[0];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dp1_reg <= s_mat_a_00 * s_mat_a_11;
            dp2_reg <= s_mat_a_10 * s_mat_a_01;
            det_reg <= DETW'(dp1_reg) - DETW'(dp2_reg);
        end
    end

    // The inverse is singular when the exact determinant is zero or its magnitude
    // falls below the threshold at the same scale.
    always_comb begin
        det_abs   = det_reg[DETW-1] ? -det_reg : det_reg;
        sing_next = (det_abs == '0) ||
                    (CMPW'(det_abs[2*DW-1:0]) < CMPW'({eps_reg, {F{1'b0}}}));
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sing_reg[0] <= sing_next;
            for (int i = 1; i <= DW + 1; i++) begin
                sing_reg[i] <= sing_reg[i-1];
            end
        end
    end

    for (genvar g = 0; g < 4; g++) begin : g_lane
        m2x2_lane #(
            .DW (DW),
            .F  (F)
        ) u_lane (
            .aclk     (aclk),
            .en       (adv),
            .x1       (op_x1[g]),
            .y1       (op_y1[g]),
            .x2       (op_x2[g]),
            .y2       (op_y2[g]),
            .numer    (op_nm[g]),
            .det      (det_reg),
            .sum      (lane_sum[g]),
            .res      (lane_res[g]),
            .res_sat  (lane_rsat[g]),
            .quot     (lane_quot[g]),
            .quot_sat (lane_qsat[g])
        );
    end

    m2x2_sqrt #(
        .DW (DW)
    ) u_sqrt (
        .aclk     (aclk),
        .en       (adv),
        .addend_a (lane_sum[0][2*DW-1:0]),
        .addend_b (lane_sum[1][2*DW-1:0]),
        .root     (root)
    );

    // Merge: pick the lane results, the divider quotients or the root by command.
    always_comb begin
        root_sat = root[DW] || root[DW-1];
        for (int i = 0; i < 4; i++) begin
            res_next[i] = '0;
        end
        sing_out_next = 1'b0;
        sat_out_next  = 1'b0;
        case (cmd_reg[LAT-1]) inside
            CMD_ADD, CMD_SUB, CMD_SCALE, CMD_ADDSCALED, CMD_MUL, CMD_VECMAT,
            CMD_MATVEC, CMD_DET, CMD_TRANSPOSE, CMD_ADJOINT: begin
                for (int i = 0; i < 4; i++) begin
                    res_next[i] = lane_res[i];
                end
                sat_out_next = lane_rsat[0] || lane_rsat[1] || lane_rsat[2] || lane_rsat[3];
            end
            CMD_NORM: begin
                res_next[0]  = root_sat ? {1'b0, {(DW-1){1'b1}}} : root[DW-1:0];
                sat_out_next = root_sat;
            end
            CMD_INVERSE: begin
                if (sing_reg[DW+1]) begin
                    for (int i = 0; i < 4; i++) begin
                        res_next[i] = lane_res[i];
                    end
                    sing_out_next = 1'b1;
                end else begin
                    for (int i = 0; i < 4; i++) begin
                        res_next[i] = lane_quot[i];
                    end
                    sat_out_next = lane_qsat[0] || lane_qsat[1] ||
                                   lane_qsat[2] || lane_qsat[3];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= valid_reg[LAT-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 4; i++) begin
                res_reg[i] <= res_next[i];
            end
            m_singular_reg  <= sing_out_next;
            m_saturated_reg <= sat_out_next;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_res_00    = res_reg[0];
    assign m_res_01    = res_reg[1];
    assign m_res_10    = res_reg[2];
    assign m_res_11    = res_reg[3];
    assign m_singular  = m_singular_reg;
    assign m_saturated = m_saturated_reg;

endmodule
